/* sv/flp_pkg.sv */
// shared types and constants of the file list record parser
package flp_pkg;

    // default field widths in bytes
    localparam int COUNT_BYTES_DEF    = 4;
    localparam int TYPE_BYTES_DEF     = 1;
    localparam int SIZE_BYTES_DEF     = 8;
    localparam int NAME_LEN_BYTES_DEF = 2;

    // result kinds, carried on m_tuser
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_NAME   = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // error stages, equal to the decode phase that was open
    localparam logic [2:0] STAGE_COUNT = 3'd0;
    localparam logic [2:0] STAGE_TYPE  = 3'd1;
    localparam logic [2:0] STAGE_SIZE  = 3'd2;
    localparam logic [2:0] STAGE_NLEN  = 3'd3;
    localparam logic [2:0] STAGE_NAME  = 3'd4;

    // output packing
    localparam int RES_DATA_W = 3 + 32 + 8 + 64 + 16 + 8;
    localparam int TDATA_W    = ((RES_DATA_W + 7) / 8) * 8;

    // output queue depth
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  error_stage;
        logic [31:0] file_index;
        logic [7:0]  type_code;
        logic [63:0] file_size;
        logic [15:0] name_length;
        logic [7:0]  name_byte;
        logic        name_last;
    } result_t;

endpackage

/* sv/file_list_record_parser.sv */
// file list record parser top level: byte decoder and output queue
//
// Decodes a serialized file list arriving one byte per request on the s_
// channel (s_tlast flags the final byte of the buffer). Layout: a
// little-endian file count, then per record a type, a size and a name
// length (all little-endian, widths set by the *_BYTES parameters) and the
// name bytes. Each record gives a header result once its name length is
// known, then one result per name byte (m_tlast on the last one). After the
// last record a done result carries the file count; later bytes of the same
// buffer are dropped. If the buffer ends before decoding is complete, a
// truncation error names the field being decoded. After the flagged byte
// all state returns to reset, so the next byte opens a new buffer.
// Rate: one input byte per clock. Every byte is decoded in the cycle it is
// accepted, against the decode state registers, and its zero, one or two
// results are written into a four-entry output queue. s_tready is high
// while the queue has room for two results, so the input stalls only when
// the m_ side holds results back; a byte that yields two results fills two
// queue entries. No reset sweep: the block takes bytes right after
// reset.
module file_list_record_parser
    import flp_pkg::*;
#(
    parameter int COUNT_BYTES    = COUNT_BYTES_DEF,
    parameter int TYPE_BYTES     = TYPE_BYTES_DEF,
    parameter int SIZE_BYTES     = SIZE_BYTES_DEF,
    parameter int NAME_LEN_BYTES = NAME_LEN_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input channel
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // data_byte
    input  logic               s_tlast,   // end_of_buffer
    // result channel
    output logic               m_tvalid,
    input  logic               m_tready,
    // error_stage[2:0], file_index[34:3], type_code[42:35], file_size[106:43],
    // name_length[122:107], name_byte[130:123], zero pad above
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,   // result_kind
    output logic               m_tlast    // name_last
);

    // decode phases, coded as the error stage they report
    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_TYPE  = 3'd1,
        PH_SIZE  = 3'd2,
        PH_NLEN  = 3'd3,
        PH_NAME  = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // decode state
    phase_t      phase_reg, phase_next;
    logic [2:0]  fbyte_reg, fbyte_next;     // bytes of the open field so far
    logic [63:0] asm_reg, asm_next;         // field under assembly
    logic [31:0] total_reg, total_next;
    logic [31:0] index_reg, index_next;
    logic [7:0]  type_reg, type_next;
    logic [63:0] size_reg, size_next;
    logic [15:0] nlen_reg, nlen_next;
    logic [15:0] left_reg, left_next;       // name bytes still to come

    // output queue
    result_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     fill_reg;

    logic        take, pop;
    logic [63:0] field_val;
    logic [3:0]  fbyte_inc, field_w;
    logic        field_full, last_record;
    logic [15:0] left_dec;
    logic        prim_v, sec_v;
    result_t     prim, sec, slot0, slot1;
    logic [1:0]  push_cnt;

    assign take = s_tvalid && s_tready;
    assign pop  = m_tvalid && m_tready;

    // room for the worst case of two results per byte
    assign s_tready = fill_reg <= CNT_W'(QUEUE_DEPTH - 2);

    // field assembly: drop the byte in at its little-endian place
    assign field_val = asm_reg | (64'(s_tdata) << {fbyte_reg, 3'b000});
    assign fbyte_inc = {1'b0, fbyte_reg} + 4'd1;

    always_comb begin
        unique case (phase_reg)
            PH_COUNT: field_w = 4'(COUNT_BYTES);
            PH_TYPE:  field_w = 4'(TYPE_BYTES);
            PH_SIZE:  field_w = 4'(SIZE_BYTES);
            PH_NLEN:  field_w = 4'(NAME_LEN_BYTES);
            default:  field_w = 4'd1;
        endcase
    end

    assign field_full  = fbyte_inc >= field_w;
    // current record is the last one of the list
    assign last_record = ({1'b0, index_reg} + 33'd1) >= {1'b0, total_reg};
    assign left_dec    = (left_reg == 16'd0) ? 16'd0 : left_reg - 16'd1;

    always_comb begin
        phase_next = phase_reg;
        fbyte_next = fbyte_reg;
        asm_next   = asm_reg;
        total_next = total_reg;
        index_next = index_reg;
        type_next  = type_reg;
        size_next  = size_reg;
        nlen_next  = nlen_reg;
        left_next  = left_reg;
        prim_v     = 1'b0;
        sec_v      = 1'b0;
        prim       = '0;
        sec        = '0;

        // shared byte counting for the fixed-width fields
        if (phase_reg != PH_NAME && phase_reg != PH_DONE) begin
            if (field_full) begin
                fbyte_next = 3'd0;
                asm_next   = '0;
            end else begin
                fbyte_next = fbyte_inc[2:0];
                asm_next   = field_val;
            end
        end

        unique case (phase_reg)
            PH_COUNT: begin
                if (field_full) begin
                    total_next = field_val[31:0];
                    index_next = '0;
                    if (field_val[31:0] == 32'd0) begin
                        // empty list: done right away
                        prim_v           = 1'b1;
                        prim.result_kind = KIND_DONE;
                        phase_next       = PH_DONE;
                    end else begin
                        phase_next = PH_TYPE;
                    end
                end
            end
            PH_TYPE: begin
                if (field_full) begin
                    type_next  = field_val[7:0];
                    phase_next = PH_SIZE;
                end
            end
            PH_SIZE: begin
                if (field_full) begin
                    size_next  = field_val;
                    phase_next = PH_NLEN;
                end
            end
            PH_NLEN: begin
                if (field_full) begin
                    nlen_next        = field_val[15:0];
                    left_next        = field_val[15:0];
                    prim_v           = 1'b1;
                    prim.result_kind = KIND_HEADER;
                    prim.file_index  = index_reg;
                    prim.type_code   = type_reg;
                    prim.file_size   = size_reg;
                    prim.name_length = field_val[15:0];
                    if (field_val[15:0] != 16'd0) begin
                        phase_next = PH_NAME;
                    end else if (last_record) begin
                        // empty name on the last record
                        sec_v           = 1'b1;
                        sec.result_kind = KIND_DONE;
                        sec.file_index  = total_reg;
                        phase_next      = PH_DONE;
                    end else begin
                        index_next = index_reg + 32'd1;
                        phase_next = PH_TYPE;
                    end
                end
            end
            PH_NAME: begin
                prim_v           = 1'b1;
                prim.result_kind = KIND_NAME;
                prim.file_index  = index_reg;
                prim.type_code   = type_reg;
                prim.file_size   = size_reg;
                prim.name_length = nlen_reg;
                prim.name_byte   = s_tdata;
                prim.name_last   = left_reg <= 16'd1;
                left_next        = left_dec;
                if (left_dec == 16'd0) begin
                    if (last_record) begin
                        sec_v           = 1'b1;
                        sec.result_kind = KIND_DONE;
                        sec.file_index  = total_reg;
                        phase_next      = PH_DONE;
                    end else begin
                        index_next = index_reg + 32'd1;
                        phase_next = PH_TYPE;
                    end
                end
            end
            default: begin
                // trailing bytes after done are dropped
                phase_next = PH_DONE;
            end
        endcase

        // buffer end: report truncation, then back to reset
        if (s_tlast) begin
            if (phase_next != PH_DONE) begin
                sec_v           = 1'b1;
                sec.result_kind = KIND_ERROR;
                sec.error_stage = phase_next;
                sec.file_index  = (phase_next == PH_COUNT) ? 32'd0 : index_next;
            end
            phase_next = PH_COUNT;
            fbyte_next = '0;
            asm_next   = '0;
            total_next = '0;
            index_next = '0;
            type_next  = '0;
            size_next  = '0;
            nlen_next  = '0;
            left_next  = '0;
        end
    end

    // pack the results into consecutive queue slots
    assign slot0    = prim_v ? prim : sec;
    assign slot1    = sec;
    assign push_cnt = take ? ({1'b0, prim_v} + {1'b0, sec_v}) : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_COUNT;
            fbyte_reg  <= '0;
            asm_reg    <= '0;
            total_reg  <= '0;
            index_reg  <= '0;
            type_reg   <= '0;
            size_reg   <= '0;
            nlen_reg   <= '0;
            left_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (take) begin
                phase_reg <= phase_next;
                fbyte_reg <= fbyte_next;
                asm_reg   <= asm_next;
                total_reg <= total_next;
                index_reg <= index_next;
                type_reg  <= type_next;
                size_reg  <= size_next;
                nlen_reg  <= nlen_next;
                left_reg  <= left_next;
            end
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fill_reg <= fill_reg + CNT_W'(push_cnt) - CNT_W'(pop);
        end
    end

    // queue storage, payload only
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            queue_reg[wr_ptr_reg] <= slot0;
        end
        if (push_cnt == 2'd2) begin
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= slot1;
        end
    end

    // queue head drives the result channel
    assign m_tvalid = fill_reg != '0;
    assign m_tuser  = queue_reg[rd_ptr_reg].result_kind;
    assign m_tlast  = queue_reg[rd_ptr_reg].name_last;
    assign m_tdata  = {
        (TDATA_W - RES_DATA_W)'(0),
        queue_reg[rd_ptr_reg].name_byte,
        queue_reg[rd_ptr_reg].name_length,
        queue_reg[rd_ptr_reg].file_size,
        queue_reg[rd_ptr_reg].type_code,
        queue_reg[rd_ptr_reg].file_index,
        queue_reg[rd_ptr_reg].error_stage
    };

endmodule

/* sv/flp_checker.sv */
// port-level checks on the result channel of the file list record parser
module flp_checker
    import flp_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [1:0]         m_tuser,
    input logic               m_tlast
);

    // nothing offered right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // last-name flag only on name bytes
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == KIND_NAME)
        else $error("name_last outside a name byte result");

    // error stage is zero unless the result is an error
    a_stage_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_ERROR |-> m_tdata[2:0] == STAGE_COUNT)
        else $error("error stage set on a non-error result");

    // an error names one of the decoded fields
    a_stage_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ERROR |->
            m_tdata[2:0] == STAGE_COUNT || m_tdata[2:0] == STAGE_TYPE
            || m_tdata[2:0] == STAGE_SIZE || m_tdata[2:0] == STAGE_NLEN
            || m_tdata[2:0] == STAGE_NAME)
        else $error("error stage out of range");

endmodule

bind file_list_record_parser flp_checker u_flp_checker (.*);
